// File: design/csm_pkg.sv
// ----------------------------------------------------------------------------
// csm_pkg
// Types, constants and the permutation table shared by the color matcher.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int NUM_ITEMS  = 4;
  localparam int NUM_PERMS  = 24;
  localparam int FIFO_DEPTH = 2;

  localparam logic [1:0]  LAST_SLOT = 2'(NUM_ITEMS - 1);
  localparam logic [4:0]  LAST_PERM = 5'(NUM_PERMS - 1);
  localparam logic [16:0] DIST_SAT  = 17'h1FFFF;
  localparam logic [17:0] COST_MAX  = 18'h3FFFF;

  // Register indexes of the configuration port.
  localparam logic [1:0] REG_REF_BLUE   = 2'd0;
  localparam logic [1:0] REG_REF_GREEN  = 2'd1;
  localparam logic [1:0] REG_REF_RED    = 2'd2;
  localparam logic [1:0] REG_REF_ORANGE = 2'd3;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SQ,
    F_ROOT,
    F_DIV,
    F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_IDLE,
    B_DSQ,
    B_DROOT,
    B_SEARCH,
    B_EMIT
  } back_state_e;

  typedef struct packed {
    logic [47:0] norm;
    logic        zero;
  } csm_entry_t;

  // Permutations in lexicographic order; bits [2c+1:2c] hold the blob for color c.
  localparam logic [7:0] PERM_TAB [NUM_PERMS] = '{
    {2'd3, 2'd2, 2'd1, 2'd0}, {2'd2, 2'd3, 2'd1, 2'd0},
    {2'd3, 2'd1, 2'd2, 2'd0}, {2'd1, 2'd3, 2'd2, 2'd0},
    {2'd2, 2'd1, 2'd3, 2'd0}, {2'd1, 2'd2, 2'd3, 2'd0},
    {2'd3, 2'd2, 2'd0, 2'd1}, {2'd2, 2'd3, 2'd0, 2'd1},
    {2'd3, 2'd0, 2'd2, 2'd1}, {2'd0, 2'd3, 2'd2, 2'd1},
    {2'd2, 2'd0, 2'd3, 2'd1}, {2'd0, 2'd2, 2'd3, 2'd1},
    {2'd3, 2'd1, 2'd0, 2'd2}, {2'd1, 2'd3, 2'd0, 2'd2},
    {2'd3, 2'd0, 2'd1, 2'd2}, {2'd0, 2'd3, 2'd1, 2'd2},
    {2'd1, 2'd0, 2'd3, 2'd2}, {2'd0, 2'd1, 2'd3, 2'd2},
    {2'd2, 2'd1, 2'd0, 2'd3}, {2'd1, 2'd2, 2'd0, 2'd3},
    {2'd2, 2'd0, 2'd1, 2'd3}, {2'd0, 2'd2, 2'd1, 2'd3},
    {2'd1, 2'd0, 2'd2, 2'd3}, {2'd0, 2'd1, 2'd2, 2'd3}
  };

  function automatic logic [1:0] perm_blob(logic [7:0] ent, logic [1:0] color);
    logic [1:0] res;
    case (color)
      2'd0:    res = ent[1:0];
      2'd1:    res = ent[3:2];
      2'd2:    res = ent[5:4];
      default: res = ent[7:6];
    endcase
    return res;
  endfunction

endpackage

// File: design/csm_isqrt.sv
// ----------------------------------------------------------------------------
// csm_isqrt
// Iterative integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module csm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  logic [63:0] rad_q;
  logic [35:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;

  logic [35:0] rem_sh, trial, rem_nx;
  logic        ge;

  always_comb begin
    rem_sh = {rem_q[33:0], rad_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = rem_sh >= trial;
    rem_nx = ge ? rem_sh - trial : rem_sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_nx;
      root_q <= {root_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// File: design/csm_front.sv
// ----------------------------------------------------------------------------
// csm_front
// Accepts blob sums and scales each blob to unit length in Q1.15.
// ----------------------------------------------------------------------------
module csm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [71:0]         s_axis_tdata,
  output logic                push_o,
  output csm_pkg::csm_entry_t entry_o,
  input  logic                full_i
);

  import csm_pkg::*;

  front_state_e state_q, state_d;

  logic [23:0] x_q [3];
  logic [1:0]  lane_q;
  logic [49:0] acc_q, acc_d;
  logic [31:0] q_q;
  logic [44:0] dvd_q [3];
  logic [44:0] quot_q [3];
  logic [32:0] rem_q [3];
  logic [5:0]  cnt_q;
  logic [47:0] norm_q;
  logic        zero_q;

  logic [47:0] sq;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [32:0] rem_sh [3];
  logic [32:0] rem_nx [3];
  logic [44:0] quot_nx [3];
  logic [15:0] lane_n [3];

  assign sq    = x_q[lane_q] * x_q[lane_q];
  assign acc_d = acc_q + {2'b00, sq};

  csm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({2'b00, acc_d, 12'h000}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // Three restoring dividers run side by side, one quotient bit per cycle.
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      rem_sh[l] = {rem_q[l][31:0], dvd_q[l][44]};
      if (rem_sh[l] >= {1'b0, q_q}) begin
        rem_nx[l]  = rem_sh[l] - {1'b0, q_q};
        quot_nx[l] = {quot_q[l][43:0], 1'b1};
      end else begin
        rem_nx[l]  = rem_sh[l];
        quot_nx[l] = {quot_q[l][43:0], 1'b0};
      end
      lane_n[l] = (|quot_nx[l][44:16]) ? 16'hFFFF : quot_nx[l][15:0];
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    push_o        = 1'b0;
    sq_start      = 1'b0;
    unique case (state_q)
      F_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = F_SQ;
      end
      F_SQ: begin
        if (lane_q == 2'd2) begin
          sq_start = 1'b1;
          state_d  = F_ROOT;
        end
      end
      F_ROOT: begin
        if (sq_done) state_d = (sq_root == '0) ? F_PUSH : F_DIV;
      end
      F_DIV: begin
        if (cnt_q == 6'd44) state_d = F_PUSH;
      end
      F_PUSH: begin
        if (!full_i) begin
          push_o  = 1'b1;
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      F_IDLE: begin
        x_q[0] <= s_axis_tdata[23:0];
        x_q[1] <= s_axis_tdata[47:24];
        x_q[2] <= s_axis_tdata[71:48];
        acc_q  <= '0;
        lane_q <= '0;
      end
      F_SQ: begin
        acc_q  <= acc_d;
        lane_q <= lane_q + 2'd1;
      end
      F_ROOT: begin
        q_q    <= sq_root;
        cnt_q  <= '0;
        norm_q <= '0;
        zero_q <= (sq_root == '0);
        for (int l = 0; l < 3; l++) begin
          dvd_q[l]  <= {x_q[l], 21'h000000};
          rem_q[l]  <= '0;
          quot_q[l] <= '0;
        end
      end
      F_DIV: begin
        cnt_q <= cnt_q + 6'd1;
        for (int l = 0; l < 3; l++) begin
          dvd_q[l]  <= {dvd_q[l][43:0], 1'b0};
          rem_q[l]  <= rem_nx[l];
          quot_q[l] <= quot_nx[l];
        end
        if (cnt_q == 6'd44) norm_q <= {lane_n[2], lane_n[1], lane_n[0]};
      end
      default: begin
      end
    endcase
  end

  assign entry_o.norm = norm_q;
  assign entry_o.zero = zero_q;

endmodule

// File: design/csm_fifo.sv
// ----------------------------------------------------------------------------
// csm_fifo
// Short queue of normalized blobs between the front and the back.
// ----------------------------------------------------------------------------
module csm_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  csm_pkg::csm_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output csm_pkg::csm_entry_t data_o,
  output logic                empty_o
);

  import csm_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  csm_entry_t       mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;

  assign full_o  = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      if (pop_i)  rd_q <= (rd_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_W'(1);
        2'b01:   cnt_q <= cnt_q - CNT_W'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("queue read while empty");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH)) else $error("queue count out of range");
`endif

endmodule

// File: design/csm_back.sv
// ----------------------------------------------------------------------------
// csm_back
// Stores a run of four blobs, builds the distance table, searches all
// assignments and sends one result beat per reference color.
// ----------------------------------------------------------------------------
module csm_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [47:0]         cfg_wdata_i,
  input  logic                empty_i,
  input  csm_pkg::csm_entry_t entry_i,
  output logic                pop_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata,
  output logic                m_axis_tuser,
  output logic                m_axis_tlast
);

  import csm_pkg::*;

  back_state_e state_q, state_d;

  logic [47:0] ref_q [NUM_ITEMS];
  logic [47:0] store_q [NUM_ITEMS];
  logic [3:0]  flags_q;
  logic [1:0]  count_q;
  logic [3:0]  pair_q;
  logic [1:0]  lane_q;
  logic [33:0] acc_q;
  logic [16:0] cost_q [16];
  logic [4:0]  perm_q, best_perm_q;
  logic [1:0]  step_q, emit_q;
  logic [18:0] total_q, best_q;

  logic [47:0] blob, refc;
  logic [15:0] a, b, d;
  logic [31:0] sq;
  logic [33:0] acc_nx;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic [1:0]  blob_sel;
  logic [16:0] cost_rd;
  logic [18:0] tot;
  logic        better;

  always_comb begin
    blob = store_q[pair_q[3:2]];
    refc = ref_q[pair_q[1:0]];
    case (lane_q)
      2'd0:    begin a = blob[15:0];  b = refc[15:0];  end
      2'd1:    begin a = blob[31:16]; b = refc[31:16]; end
      default: begin a = blob[47:32]; b = refc[47:32]; end
    endcase
    d      = (a >= b) ? a - b : b - a;
    sq     = d * d;
    acc_nx = acc_q + {2'b00, sq};
  end

  csm_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i ({30'h0, acc_nx}),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  // One table read per cycle; the fourth read of a permutation closes its total.
  always_comb begin
    blob_sel = perm_blob(PERM_TAB[perm_q], step_q);
    cost_rd  = cost_q[{blob_sel, step_q}];
    tot      = ((step_q == 2'd0) ? 19'd0 : total_q) + {2'b00, cost_rd};
    better   = (perm_q == 5'd0) || (tot < best_q);
  end

  always_comb begin
    state_d       = state_q;
    pop_o         = 1'b0;
    sq_start      = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (count_q == LAST_SLOT) state_d = B_DSQ;
        end
      end
      B_DSQ: begin
        if (lane_q == 2'd2) begin
          sq_start = 1'b1;
          state_d  = B_DROOT;
        end
      end
      B_DROOT: begin
        if (sq_done) state_d = (pair_q == 4'd15) ? B_SEARCH : B_DSQ;
      end
      B_SEARCH: begin
        if (step_q == 2'd3 && perm_q == LAST_PERM) state_d = B_EMIT;
      end
      B_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready && emit_q == LAST_SLOT) state_d = B_IDLE;
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      count_q <= '0;
      flags_q <= '0;
      emit_q  <= '0;
      for (int i = 0; i < NUM_ITEMS; i++) ref_q[i] <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) ref_q[cfg_addr_i] <= cfg_wdata_i;
      if (pop_o) begin
        flags_q[count_q] <= entry_i.zero;
        if (count_q != LAST_SLOT) count_q <= count_q + 2'd1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        emit_q <= emit_q + 2'd1;
        if (emit_q == LAST_SLOT) begin
          count_q <= '0;
          flags_q <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      B_IDLE: begin
        if (pop_o) store_q[count_q] <= entry_i.norm;
        pair_q <= '0;
        lane_q <= '0;
        acc_q  <= '0;
      end
      B_DSQ: begin
        acc_q  <= acc_nx;
        lane_q <= lane_q + 2'd1;
      end
      B_DROOT: begin
        if (sq_done) begin
          cost_q[pair_q] <= flags_q[pair_q[3:2]] ? DIST_SAT : sq_root[16:0];
          pair_q <= pair_q + 4'd1;
          lane_q <= '0;
          acc_q  <= '0;
          perm_q <= '0;
          step_q <= '0;
        end
      end
      B_SEARCH: begin
        total_q <= tot;
        step_q  <= step_q + 2'd1;
        if (step_q == 2'd3) begin
          perm_q <= perm_q + 5'd1;
          if (better) begin
            best_q      <= tot;
            best_perm_q <= perm_q;
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = {2'b00, (best_q[18] ? COST_MAX : best_q[17:0]),
                         perm_blob(PERM_TAB[best_perm_q], emit_q), emit_q};
  assign m_axis_tuser = |flags_q;
  assign m_axis_tlast = (emit_q == LAST_SLOT);

`ifndef ASSERT_OFF
  a_emit_full_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> count_q == LAST_SLOT) else $error("result beat without a full run");
  a_run_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (count_q == '0 && flags_q == '0))
    else $error("run state not cleared after last beat");
  a_root_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == B_DROOT) else $error("root finished outside table build");
`endif

endmodule

// File: design/color_blob_assignment_matcher_core.sv
// ----------------------------------------------------------------------------
// color_blob_assignment_matcher_core
// Matches four blobs to four reference colors by the least total distance.
// ----------------------------------------------------------------------------
// In the front each input beat is squared and summed lane by lane, then goes
// through a square root and through three parallel dividers.
// The fourth blob of a run starts the back, which builds the 16-entry distance
// table (one shared square root unit) and then searches all 24
// assignments, one table read per cycle, before four result beats follow.
// Reset clears the control state, the run and the reference colors to zero.
// ----------------------------------------------------------------------------
module color_blob_assignment_matcher_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,   // blue_sum, green_sum, red_sum
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // color_slot, blob_index, total_cost
  output logic        m_axis_tuser,   // bad_blob
  output logic        m_axis_tlast,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [47:0] cfg_wdata_i
);

  import csm_pkg::*;

  csm_entry_t push_data, pop_data;
  logic       push, full, pop, empty;

  csm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_o        (push),
    .entry_o       (push_data),
    .full_i        (full)
  );

  csm_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_data),
    .empty_o (empty)
  );

  csm_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .empty_i       (empty),
    .entry_i       (pop_data),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
